[hw/rtl/wwj_pkg.sv]
// Package with the state type and the constants of the word-wrap line justifier.
`default_nettype none

package wwj_pkg;

    localparam logic [1:0] MODE_VERBATIM = 2'd0;
    localparam logic [1:0] MODE_LEFT     = 2'd1;
    localparam logic [1:0] MODE_CENTER   = 2'd2;
    localparam logic [1:0] MODE_RIGHT    = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_VB_PUT,
        S_VB_LIM,
        S_APPEND,
        S_BAR_PAD,
        S_END_CHECK,
        S_FIN_START,
        S_FIN_PAD,
        S_DONE,
        S_PW_START,
        S_PW_ROOM,
        S_PW_WORD,
        S_PW_SPACE,
        S_PW_PAD,
        S_PW_LIM,
        S_FL_INIT,
        S_FL_SCAN,
        S_FL_EMIT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/wwj_in_if.sv]
// Channel interface that carries one message character beat.
`default_nettype none

interface wwj_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       msg_last;

    modport source (output valid, output in_char, output msg_last, input ready);
    modport sink (input valid, input in_char, input msg_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/wwj_out_if.sv]
// Channel interface that carries one formatted display character beat.
`default_nettype none

interface wwj_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       msg_done;

    modport source (output valid, output out_char, output run_last, output msg_done,
                    input ready);
    modport sink (input valid, input out_char, input run_last, input msg_done,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/word_wrap_line_justifier.sv]
// Top level of the greedy word-wrap line justifier for a fixed-width display.
//
// Message characters enter on i_in, one beat per character; a beat with a zero
// character or msg_last ends the message, as does the MAX_CHARS-th character.
// Formatted characters leave on o_out. run_last marks the last beat caused by
// one input beat and msg_done the final character of the formatted message.
// The user writes the justify mode register through i_cfg_we and i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// A small sequencer steps one character move per cycle through the line and
// word buffers, unless a stalled receiver holds an emit: each placed or padded
// character is one move, the trailing space scan of a centered or right line
// looks at up to LINE_LEN characters, and each emitted character is one move.
// The block takes a new beat only when the previous one is fully processed.
// Results pass through a one-beat hold stage and an output register, so a
// stalled receiver only holds the sequencer when a further character must be
// emitted. Synchronous reset empties both buffers logically and clears the
// fill, word-length, emit and accepted-character counters and the mode
// register; no clearing pass follows reset.
`default_nettype none

module word_wrap_line_justifier #(
    parameter int MAX_CHARS = 64,
    parameter int LINE_LEN  = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [1:0] i_cfg_wdata,
    wwj_in_if.sink     i_in,
    wwj_out_if.source  o_out
);
    import wwj_pkg::*;

    localparam int LW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int CW = $clog2(LINE_LEN + 1);
    localparam int MW = $clog2(MAX_CHARS + 1);
    localparam int SW = ((MW > CW) ? MW : CW) + 1;
    localparam logic [CW-1:0] LINE_LEN_C = CW'(LINE_LEN);
    localparam logic [MW-1:0] MAX_C      = MW'(MAX_CHARS);
    localparam logic [SW-1:0] MAX_S      = SW'(MAX_CHARS);
    localparam logic [LW-1:0] LAST_IDX   = LW'(LINE_LEN - 1);

    t_state r_state, n_state;
    t_state r_pw_ret, n_pw_ret;
    t_state r_fl_ret, n_fl_ret;

    logic [1:0]    r_mode;
    logic [7:0]    r_line [LINE_LEN];
    logic [7:0]    r_word [LINE_LEN];
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_wlen, n_wlen;
    logic [MW-1:0] r_emit, n_emit;
    logic [MW-1:0] r_acc, n_acc;
    logic          r_fin, n_fin;
    logic          r_skip, n_skip;
    logic          r_end, n_end;
    logic [7:0]    r_c, n_c;
    logic          r_last, n_last;
    logic [CW-1:0] r_pw_len, n_pw_len;
    logic [CW-1:0] r_room, n_room;
    logic          r_fit, n_fit;
    logic          r_pass, n_pass;
    logic          r_fl_final, n_fl_final;
    logic [LW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_hold_v, n_hold_v;
    logic [7:0]    r_hold_c, n_hold_c;
    logic          r_hold_done, n_hold_done;
    logic          r_out_v, n_out_v;
    logic [7:0]    r_out_c, n_out_c;
    logic          r_out_rl, n_out_rl;
    logic          r_out_md, n_out_md;

    logic          w_put_en;
    logic [7:0]    w_put_ch;
    logic          w_wput_en;

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_emit_ok;
    logic [SW-1:0] w_sum;
    logic          w_lim;
    logic          w_drain;
    logic          w_full;
    logic [SW-1:0] w_cap;
    logic [CW-1:0] w_rem;
    logic [CW-1:0] w_room;
    logic          w_fit;
    logic [7:0]    w_line_rd;
    logic [7:0]    w_word_rd;
    logic          w_scan_sp;
    logic          w_scan_done;
    logic [CW-1:0] w_t_next;
    logic [CW-1:0] w_amt_raw;
    logic [CW-1:0] w_amt;
    logic [LW-1:0] w_start;
    logic [MW-1:0] w_acc_next;
    logic          w_end_d;
    logic          w_take;
    logic          w_rotate;
    logic          w_emit_last;
    logic [LW-1:0] w_idx_inc;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_v || o_out.ready;
    assign w_emit_ok  = !r_hold_v || w_out_free;
    assign w_sum      = SW'(r_emit) + SW'(r_fill);
    assign w_lim      = w_sum >= MAX_S;
    assign w_drain    = r_emit >= MAX_C;
    assign w_full     = r_fill >= LINE_LEN_C;
    assign w_cap      = w_lim ? '0 : (MAX_S - w_sum);
    assign w_rem      = LINE_LEN_C - r_fill;
    assign w_room     = (w_cap < SW'(w_rem)) ? CW'(w_cap) : w_rem;
    assign w_fit      = (r_pw_len != '0) && (r_pw_len <= w_room);
    assign w_line_rd  = r_line[r_idx];
    assign w_word_rd  = r_word[r_idx];
    assign w_scan_sp  = w_line_rd == CH_SPACE;
    assign w_scan_done = !w_scan_sp || (r_idx == '0);
    assign w_t_next   = r_cnt + CW'(w_scan_sp);
    assign w_amt_raw  = (r_mode == MODE_RIGHT) ? w_t_next : (w_t_next >> 1);
    assign w_amt      = (w_amt_raw == LINE_LEN_C) ? '0 : w_amt_raw;
    assign w_start    = (w_amt == '0) ? '0 : LW'(LINE_LEN_C - w_amt);
    assign w_acc_next = (r_acc < MAX_C) ? r_acc + 1'b1 : r_acc;
    assign w_end_d    = (r_c == CH_NUL) || r_last || (w_acc_next >= MAX_C);
    assign w_take     = (r_c != CH_NUL) && !w_drain;
    assign w_rotate   = (r_fill == LINE_LEN_C) &&
                        ((r_mode == MODE_CENTER) || (r_mode == MODE_RIGHT));
    assign w_emit_last = r_cnt == (r_fill - 1'b1);
    assign w_idx_inc  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!w_take) begin
                    n_state = S_END_CHECK;
                end else if (r_mode == MODE_VERBATIM) begin
                    n_state = w_full ? S_FL_INIT : S_VB_PUT;
                end else if (r_c == CH_SPACE) begin
                    n_state = (r_wlen != '0) ? S_PW_START : S_END_CHECK;
                end else if (r_c == CH_BAR) begin
                    n_state = S_PW_START;
                end else begin
                    n_state = (r_wlen >= LINE_LEN_C) ? S_PW_START : S_APPEND;
                end
            end
            S_VB_PUT: n_state = S_VB_LIM;
            S_VB_LIM: n_state = w_lim ? S_FL_INIT : S_END_CHECK;
            S_APPEND: n_state = S_END_CHECK;
            S_BAR_PAD: n_state = S_PW_START;
            S_END_CHECK: begin
                n_state = (r_end && !w_drain) ? S_FIN_START : S_DONE;
            end
            S_FIN_START: begin
                if ((r_mode != MODE_VERBATIM) && ((r_wlen != '0) || r_skip)) begin
                    n_state = S_PW_START;
                end else begin
                    n_state = S_FIN_PAD;
                end
            end
            S_FIN_PAD: begin
                if (w_drain || (r_fill == '0)) begin
                    n_state = S_DONE;
                end else if ((r_mode != MODE_VERBATIM) && !w_full && !w_lim) begin
                    n_state = S_FIN_PAD;
                end else begin
                    n_state = S_FL_INIT;
                end
            end
            S_DONE: begin
                if (w_emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_PW_START: begin
                if (w_drain) begin
                    n_state = r_pw_ret;
                end else if (w_full) begin
                    n_state = S_FL_INIT;
                end else begin
                    n_state = S_PW_ROOM;
                end
            end
            S_PW_ROOM: begin
                if (w_fit) begin
                    n_state = S_PW_WORD;
                end else if (w_room == '0) begin
                    n_state = S_PW_LIM;
                end else begin
                    n_state = S_PW_PAD;
                end
            end
            S_PW_WORD: begin
                if (CW'(r_idx) == (r_pw_len - 1'b1)) begin
                    n_state = S_PW_SPACE;
                end
            end
            S_PW_SPACE: n_state = S_PW_LIM;
            S_PW_PAD: begin
                if (r_cnt == CW'(1)) begin
                    n_state = S_PW_LIM;
                end
            end
            S_PW_LIM: begin
                if (w_lim) begin
                    n_state = S_FL_INIT;
                end else if (r_fit || (r_pw_len == '0) || r_pass) begin
                    n_state = r_pw_ret;
                end else begin
                    n_state = S_PW_START;
                end
            end
            S_FL_INIT: begin
                if (r_fill == '0) begin
                    n_state = r_fl_ret;
                end else if (w_rotate) begin
                    n_state = S_FL_SCAN;
                end else begin
                    n_state = S_FL_EMIT;
                end
            end
            S_FL_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_FL_EMIT;
                end
            end
            S_FL_EMIT: begin
                if (w_emit_ok && w_emit_last) begin
                    n_state = r_fl_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_fill      = r_fill;
        n_wlen      = r_wlen;
        n_emit      = r_emit;
        n_acc       = r_acc;
        n_fin       = r_fin;
        n_skip      = r_skip;
        n_end       = r_end;
        n_c         = r_c;
        n_last      = r_last;
        n_pw_len    = r_pw_len;
        n_pw_ret    = r_pw_ret;
        n_room      = r_room;
        n_fit       = r_fit;
        n_pass      = r_pass;
        n_fl_final  = r_fl_final;
        n_fl_ret    = r_fl_ret;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_hold_v    = r_hold_v;
        n_hold_c    = r_hold_c;
        n_hold_done = r_hold_done;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_c     = r_out_c;
        n_out_rl    = r_out_rl;
        n_out_md    = r_out_md;
        w_put_en    = 1'b0;
        w_put_ch    = CH_SPACE;
        w_wput_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_c    = i_in.in_char;
                    n_last = i_in.msg_last;
                    if (r_fin) begin
                        n_fill = '0;
                        n_wlen = '0;
                        n_emit = '0;
                        n_acc  = '0;
                        n_skip = 1'b0;
                        n_fin  = 1'b0;
                    end
                end
            end
            S_DISPATCH: begin
                if (r_c != CH_NUL) begin
                    n_acc = w_acc_next;
                end
                n_end = w_end_d;
                n_pass = 1'b0;
                if (w_take) begin
                    if (r_mode == MODE_VERBATIM) begin
                        n_fl_final = 1'b0;
                        n_fl_ret   = S_VB_PUT;
                    end else if (r_c == CH_SPACE) begin
                        n_skip   = 1'b1;
                        n_pw_len = r_wlen;
                        n_pw_ret = S_END_CHECK;
                        n_wlen   = '0;
                    end else if (r_c == CH_BAR) begin
                        n_skip   = 1'b0;
                        n_pw_len = r_wlen;
                        n_pw_ret = (r_wlen != '0) ? S_BAR_PAD : S_END_CHECK;
                        n_wlen   = '0;
                    end else begin
                        n_skip = 1'b0;
                        if (r_wlen >= LINE_LEN_C) begin
                            n_pw_len = r_wlen;
                            n_pw_ret = S_APPEND;
                            n_wlen   = '0;
                        end
                    end
                end
            end
            S_VB_PUT: begin
                w_put_en = !w_full;
                w_put_ch = r_c;
                if (!w_full) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            S_VB_LIM: begin
                n_fl_final = 1'b1;
                n_fl_ret   = S_END_CHECK;
            end
            S_APPEND: begin
                w_wput_en = 1'b1;
                n_wlen    = r_wlen + 1'b1;
            end
            S_BAR_PAD: begin
                n_pw_len = '0;
                n_pw_ret = S_END_CHECK;
                n_pass   = 1'b0;
            end
            S_FIN_START: begin
                n_pw_len = r_wlen;
                n_pw_ret = S_FIN_PAD;
                n_pass   = 1'b0;
                n_wlen   = '0;
                n_skip   = 1'b0;
            end
            S_FIN_PAD: begin
                n_fl_final = 1'b1;
                n_fl_ret   = S_DONE;
                if (!w_drain && (r_fill != '0) && (r_mode != MODE_VERBATIM) &&
                    !w_full && !w_lim) begin
                    w_put_en = 1'b1;
                    n_fill   = r_fill + 1'b1;
                end
            end
            S_DONE: begin
                if (w_emit_ok) begin
                    n_fin = r_end;
                    if (r_hold_v) begin
                        n_out_v  = 1'b1;
                        n_out_c  = r_hold_c;
                        n_out_rl = 1'b1;
                        n_out_md = r_hold_done;
                        n_hold_v = 1'b0;
                    end
                end
            end
            S_PW_START: begin
                n_fl_final = 1'b0;
                n_fl_ret   = S_PW_ROOM;
            end
            S_PW_ROOM: begin
                n_room = w_room;
                n_fit  = w_fit;
                n_idx  = '0;
                n_cnt  = w_room;
            end
            S_PW_WORD: begin
                w_put_en = !w_full;
                w_put_ch = w_word_rd;
                if (!w_full) begin
                    n_fill = r_fill + 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end
            S_PW_SPACE: begin
                if ((r_room > r_pw_len) && !w_full) begin
                    w_put_en = 1'b1;
                    n_fill   = r_fill + 1'b1;
                end
            end
            S_PW_PAD: begin
                w_put_en = !w_full;
                if (!w_full) begin
                    n_fill = r_fill + 1'b1;
                end
                n_cnt = r_cnt - 1'b1;
            end
            S_PW_LIM: begin
                n_fl_final = 1'b1;
                n_fl_ret   = r_pw_ret;
                if (!w_lim && !r_fit && (r_pw_len != '0) && !r_pass) begin
                    n_pass = 1'b1;
                end
            end
            S_FL_INIT: begin
                n_cnt = '0;
                n_idx = w_rotate ? LAST_IDX : '0;
            end
            S_FL_SCAN: begin
                if (w_scan_done) begin
                    n_idx = w_start;
                    n_cnt = '0;
                end else begin
                    n_idx = r_idx - 1'b1;
                    n_cnt = w_t_next;
                end
            end
            S_FL_EMIT: begin
                if (w_emit_ok) begin
                    if (r_hold_v) begin
                        n_out_v  = 1'b1;
                        n_out_c  = r_hold_c;
                        n_out_rl = 1'b0;
                        n_out_md = r_hold_done;
                    end
                    n_hold_v    = 1'b1;
                    n_hold_c    = w_line_rd;
                    n_hold_done = r_fl_final && w_emit_last;
                    n_idx       = w_idx_inc;
                    n_cnt       = r_cnt + 1'b1;
                    if (w_emit_last) begin
                        n_emit = MW'(w_sum);
                        n_fill = '0;
                    end
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_VERBATIM;
            r_fill   <= '0;
            r_wlen   <= '0;
            r_emit   <= '0;
            r_acc    <= '0;
            r_fin    <= 1'b0;
            r_skip   <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_wlen   <= n_wlen;
            r_emit   <= n_emit;
            r_acc    <= n_acc;
            r_fin    <= n_fin;
            r_skip   <= n_skip;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_c         <= n_c;
        r_last      <= n_last;
        r_pw_len    <= n_pw_len;
        r_pw_ret    <= n_pw_ret;
        r_room      <= n_room;
        r_fit       <= n_fit;
        r_pass      <= n_pass;
        r_fl_final  <= n_fl_final;
        r_fl_ret    <= n_fl_ret;
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_hold_c    <= n_hold_c;
        r_hold_done <= n_hold_done;
        r_out_c     <= n_out_c;
        r_out_rl    <= n_out_rl;
        r_out_md    <= n_out_md;
    end

    always_ff @(posedge i_clk) begin
        if (w_put_en) begin
            r_line[r_fill[LW-1:0]] <= w_put_ch;
        end
        if (w_wput_en) begin
            r_word[r_wlen[LW-1:0]] <= r_c;
        end
    end

    assign i_in.ready     = r_state == S_IDLE;
    assign o_out.valid    = r_out_v;
    assign o_out.out_char = r_out_c;
    assign o_out.run_last = r_out_rl;
    assign o_out.msg_done = r_out_md;

endmodule

`default_nettype wire

[hw/rtl/wwj_checker.sv]
// Port-level checker for the word-wrap line justifier and its bind statement.
`default_nettype none

module wwj_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_char,
    input wire       i_out_run_last,
    input wire       i_out_msg_done
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("Input was ready again right after an accepted beat.");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_msg_done) |-> i_out_run_last)
        else $error("Message end beat was not the last beat of its run.");

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output beat was valid right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_run_last) &&
             $stable(i_out_msg_done)))
        else $error("Stalled output beat changed.");

endmodule

bind word_wrap_line_justifier wwj_checker u_wwj_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_char     (o_out.out_char),
    .i_out_run_last (o_out.run_last),
    .i_out_msg_done (o_out.msg_done)
);

`default_nettype wire
